FILE: sv/visual_crypto_share_expander_top_defines.svh
// Assertion macros for the share expander checker.
`ifndef VISUAL_CRYPTO_SHARE_EXPANDER_TOP_DEFINES_SVH
`define VISUAL_CRYPTO_SHARE_EXPANDER_TOP_DEFINES_SVH

// Assert a property on the rising clock edge, quiet while reset is held.
`define VCSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert that a condition in one cycle implies another in the next cycle.
`define VCSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/vcse_pkg.sv
// Package: constants, types and state codes of the share expander.
`timescale 1ns / 1ps
`default_nettype none

package vcse_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int STORE_DEPTH = (MAX_WIDTH + 3) / 4;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int COL_W       = $clog2(MAX_WIDTH);

	localparam logic [7:0] WIDTH_RESET = 8'd8;

	// Subpixel pair codes.
	localparam logic [1:0] PAIR_10 = 2'b10;
	localparam logic [1:0] PAIR_01 = 2'b01;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	// What the packer decides for one accepted item.
	typedef struct packed {
		logic              emit;
		logic              row_end;
		logic [7:0]        share_one;
		logic [7:0]        share_two;
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       store_data;
	} pack_res_t;

endpackage

`default_nettype wire

FILE: sv/vcse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module vcse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/vcse_pack.sv
// Subpixel expansion, top-row packing and bottom-row byte building.
`timescale 1ns / 1ps
`default_nettype none

module vcse_pack
	import vcse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       pixel_bit,
	input  wire logic       key_bit,
	input  wire logic [7:0] eff_width,
	output      pack_res_t  res
);

	logic [COL_W-1:0] col_q;
	logic [5:0]       top1_q, top2_q, bot1_q, bot2_q;

	logic [1:0] top1, top2;
	logic [7:0] top1_n, top2_n, bot1_n, bot2_n;
	logic [7:0] taken;
	logic [1:0] phase, neg_phase;
	logic [2:0] shamt;
	logic       full, row_end;
	logic [7:0] bot1_sh, bot2_sh;

	always_comb begin
		top1      = key_bit ? PAIR_01 : PAIR_10;
		top2      = (pixel_bit ^ key_bit) ? PAIR_01 : PAIR_10;
		top1_n    = {top1_q, top1};
		top2_n    = {top2_q, top2};
		bot1_n    = {bot1_q, ~top1};
		bot2_n    = {bot2_q, ~top2};
		taken     = {1'b0, col_q} + 8'd1;
		phase     = taken[1:0];
		full      = (phase == 2'd0);
		row_end   = (taken >= eff_width);
		// pad a partial byte: shift left by two bits per missing pixel
		neg_phase = 2'd0 - phase;
		shamt     = {neg_phase, 1'b0};
		bot1_sh   = bot1_n << shamt;
		bot2_sh   = bot2_n << shamt;

		res.emit       = full || row_end;
		res.row_end    = row_end;
		res.share_one  = top1_n << shamt;
		res.share_two  = top2_n << shamt;
		res.we         = full || row_end;
		res.slot       = col_q[COL_W-1:2];
		res.store_data = {bot1_sh, bot2_sh};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			top1_q <= '0;
			top2_q <= '0;
			bot1_q <= '0;
			bot2_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
			end else begin
				col_q <= taken[COL_W-1:0];
			end
			if (row_end || full) begin
				top1_q <= '0;
				top2_q <= '0;
				bot1_q <= '0;
				bot2_q <= '0;
			end else begin
				top1_q <= top1_n[5:0];
				top2_q <= top2_n[5:0];
				bot1_q <= bot1_n[5:0];
				bot2_q <= bot2_n[5:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/visual_crypto_share_expander_top.sv
// Top level: stream ports, width register, drain sequencer and result register.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  s_tdata: pixel_bit, key_bit
//   m_*       out   m_tvalid/m_tready  m_tdata: share_one_byte, share_two_byte; m_tlast: last
//   cfg_*     in    cfg_we             cfg_wdata: image_width
//
// An item that ends no row is taken in S_IDLE. A row-end item goes on to S_READ, the
// first read of the bottom-row RAM, then to S_EMIT, one bottom byte per cycle unless
// stalled, ceil(pixels / 4) bytes, at most 32: the RAM's single read port sets that pace.
// Reset clears the counters, accumulators and sequencer; the RAM is not cleared,
// since a row reads back only entries it has written. A stall on m_tready holds the
// result register and stops the drain and input acceptance.
`timescale 1ns / 1ps
`default_nettype none

module visual_crypto_share_expander_top
	import vcse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] pixel_bit, [1] key_bit, [7:2] zero
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata,   // [7:0] share_one_byte, [15:8] share_two_byte
	output      logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	state_t            state_q;
	logic [SLOT_W-1:0] idx_q, end_q;
	logic [7:0]        width_q;
	logic              ov_q, ol_q;
	logic [15:0]       od_q;

	logic [7:0]        eff_width;
	logic              out_free, accept;
	pack_res_t         res;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	always_comb begin
		priority if (width_q == 8'd0) begin
			eff_width = 8'd1;
		end else if (width_q > 8'(MAX_WIDTH)) begin
			eff_width = 8'(MAX_WIDTH);
		end else begin
			eff_width = width_q;
		end
	end

	assign out_free = !ov_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tlast  = ol_q;

	vcse_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel_bit (s_tdata[0]),
		.key_bit   (s_tdata[1]),
		.eff_width (eff_width),
		.res       (res)
	);

	// prefetch the next bottom byte as the current one moves to the result register
	always_comb begin
		unique case (state_q)
			S_READ: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q;
			end
			S_EMIT: begin
				ram_re    = out_free && (idx_q != end_q);
				ram_raddr = idx_q + SLOT_W'(1);
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = idx_q;
			end
		endcase
	end

	vcse_ram #(
		.WIDTH (16),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && res.we),
		.waddr (res.slot),
		.wdata (res.store_data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			end_q   <= '0;
			width_q <= WIDTH_RESET;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && res.emit) begin
						ov_q <= 1'b1;
					end else if (m_tready) begin
						ov_q <= 1'b0;
					end
					if (accept && res.row_end) begin
						state_q <= S_READ;
						idx_q   <= '0;
						end_q   <= res.slot;
					end
				end
				S_READ: begin
					if (m_tready) begin
						ov_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						if (idx_q == end_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + SLOT_W'(1);
						end
					end
				end
				default: begin
					if (m_tready) begin
						ov_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && res.emit) begin
			od_q <= {res.share_two, res.share_one};
			ol_q <= !res.row_end;
		end else if (state_q == S_EMIT && out_free) begin
			od_q <= {ram_rdata[7:0], ram_rdata[15:8]};
			ol_q <= (idx_q == end_q);
		end
	end

endmodule

`default_nettype wire

FILE: sv/vcse_checker.sv
// Port-level checker for the share expander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "visual_crypto_share_expander_top_defines.svh"

module vcse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast
);

	logic        stall;
	logic [16:0] out_word;

	assign stall    = m_tvalid && !m_tready;
	assign out_word = {m_tlast, m_tdata};

	// hold a stalled result
	`VCSE_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(out_word), "stalled item changed")

	// a pending bottom-row drain blocks new input
	`VCSE_ASSERT(a_drain_blocks, !(m_tvalid && !m_tlast && s_tready), "input taken during drain")

	// input is taken only when the result register can take a result
	`VCSE_ASSERT(a_out_room, !(s_tvalid && s_tready && stall), "input taken with result stalled")

endmodule

bind visual_crypto_share_expander_top vcse_checker u_vcse_checker (.*);

`default_nettype wire
